// ===== rtl/core/bb3_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants for the 3x3 clamped box blur
// Holds size defaults, register indexes, stream codes, the controller state
// type and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int CFG_W_BITS = 11;
    localparam int CFG_H_BITS = 13;
    localparam int CFG_D_BITS = 13;

    localparam logic [CFG_W_BITS-1:0] RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [CFG_H_BITS-1:0] RST_FRAME_HEIGHT = 13'd1024;

    // register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // item kinds on tuser
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // rounding divide by reciprocal multiply:
    // quotient = (num * ceil(2^17 / 2n)) >> 17, exact for num below 4600
    localparam int NUM_BITS    = 13;
    localparam int RECIP_BITS  = 17;
    localparam int RECIP_SHIFT = 17;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_RD_LAST,
        ST_DIV_LD,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic       acc_clr;
        logic       div_start;
        logic       div_step;
        logic       out_load;
        logic       out_last;
        logic [3:0] count;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== rtl/core/bb3_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_dp: blur datapath
// Four-row pixel store, per-channel accumulators, reciprocal-multiply
// rounding divide and the output register of the result stream.
// ----------------------------------------------------------------------------
module bb3_dp
    import bb3_pkg::*;
#(
    parameter int CW = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_dp_cmd       i_cmd,
    output t_dp_sts            o_sts,
    input  wire logic [1:0]    i_wr_row,
    input  wire logic [CW-1:0] i_wr_col,
    input  wire logic [23:0]   i_wr_data,
    input  wire logic [1:0]    i_rd_row,
    input  wire logic [CW-1:0] i_rd_col,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [23:0]        o_out_data,
    output logic               o_out_last
);

    localparam int DEPTH = 4 * (2 ** CW);
    localparam int PW    = NUM_BITS + RECIP_BITS;

    logic [23:0]           mem [DEPTH];
    logic [23:0]           r_rd_data;
    logic                  r_acc_en;
    logic [11:0]           r_sum [3];
    logic [NUM_BITS-1:0]   r_num [3];
    logic [RECIP_BITS-1:0] r_recip;
    logic [7:0]            r_quot [3];
    logic                  r_out_valid;
    logic [23:0]           r_out_data;
    logic                  r_out_last;

    logic [RECIP_BITS-1:0] recip;
    logic [PW-1:0]         prod [3];
    logic [23:0]           n_out_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[{i_wr_row, i_wr_col}] <= i_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[{i_rd_row, i_rd_col}];
        end
    end

    always_comb begin
        // ceil(2^17 / 2n) for each neighbourhood size n
        case (i_cmd.count)
            4'd1:    recip = RECIP_BITS'(65536);
            4'd2:    recip = RECIP_BITS'(32768);
            4'd3:    recip = RECIP_BITS'(21846);
            4'd4:    recip = RECIP_BITS'(16384);
            4'd6:    recip = RECIP_BITS'(10923);
            4'd9:    recip = RECIP_BITS'(7282);
            default: recip = '0;
        endcase
        for (int k = 0; k < 3; k++) begin
            prod[k] = PW'(r_num[k]) * PW'(r_recip);
        end
        n_out_data = {r_quot[2], r_quot[1], r_quot[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= i_cmd.rd_en;
        end
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.acc_clr) begin
                r_sum[k] <= '0;
            end else if (r_acc_en) begin
                r_sum[k] <= r_sum[k] + 12'(r_rd_data[8*k +: 8]);
            end
            if (i_cmd.div_start) begin
                // numerator 2*sum + n, rounds ties up
                r_num[k] <= NUM_BITS'({r_sum[k], 1'b0}) + NUM_BITS'(i_cmd.count);
            end
            if (i_cmd.div_step) begin
                r_quot[k] <= prod[k][RECIP_SHIFT +: 8];
            end
        end
        if (i_cmd.div_start) begin
            r_recip <= recip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_data <= n_out_data;
            r_out_last <= i_cmd.out_last;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;
    assign o_out_last     = r_out_last;

endmodule
`default_nettype wire

// ===== rtl/core/bb3_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_ctrl: blur controller
// Frame size registers, input/output raster counters, neighbourhood
// readiness check, window read sequencing and divide sequencing.
// ----------------------------------------------------------------------------
module bb3_ctrl
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int CW         = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_idx,
    input  wire logic [CFG_D_BITS-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_mode,
    output logic                       o_in_ready,
    output t_dp_cmd                    o_cmd,
    input  wire t_dp_sts               i_sts,
    output logic [1:0]                 o_wr_row,
    output logic [CW-1:0]              o_wr_col,
    output logic [1:0]                 o_rd_row,
    output logic [CW-1:0]              o_rd_col
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW0 = $clog2(MAX_HEIGHT + 1);
    localparam int HW  = (HW0 < 2) ? 2 : HW0;

    t_state                r_state, n_state;
    logic [CFG_W_BITS-1:0] r_cfg_w, n_cfg_w;
    logic [CFG_H_BITS-1:0] r_cfg_h, n_cfg_h;
    logic [HW-1:0]         r_in_row, n_in_row, r_out_row, n_out_row;
    logic [WW-1:0]         r_in_col, n_in_col, r_out_col, n_out_col;
    logic                  r_draining, n_draining;
    logic [HW-1:0]         r_rd_row, n_rd_row, r_r1, n_r1;
    logic [WW-1:0]         r_rd_col, n_rd_col, r_c0, n_c0, r_c1, n_c1;
    logic [3:0]            r_count, n_count;

    logic [WW-1:0] aw;
    logic [HW-1:0] ah;
    logic [HW-1:0] rneed, r0;
    logic [WW-1:0] cneed, c0;
    logic [1:0]    nr, nc;
    logic          win_ready;
    logic          frame_end;

    // clamp the frame size into 1..MAX
    always_comb begin
        if (r_cfg_w == '0) begin
            aw = WW'(1);
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            aw = WW'(MAX_WIDTH);
        end else begin
            aw = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            ah = HW'(1);
        end else if (32'(r_cfg_h) > 32'(MAX_HEIGHT)) begin
            ah = HW'(MAX_HEIGHT);
        end else begin
            ah = HW'(r_cfg_h);
        end
    end

    always_comb begin
        rneed = (r_out_row < ah - 1'b1) ? r_out_row + 1'b1 : ah - 1'b1;
        cneed = (r_out_col < aw - 1'b1) ? r_out_col + 1'b1 : aw - 1'b1;
        r0    = (r_out_row != '0) ? r_out_row - 1'b1 : '0;
        c0    = (r_out_col != '0) ? r_out_col - 1'b1 : '0;
        nr    = 2'(rneed - r0) + 2'd1;
        nc    = 2'(cneed - c0) + 2'd1;
        win_ready = r_draining || (r_in_row > rneed)
                 || ((r_in_row == rneed) && (r_in_col > cneed));
        frame_end = (r_out_row == ah - 1'b1) && (r_out_col == aw - 1'b1);
    end

    always_comb begin
        n_state    = r_state;
        n_cfg_w    = r_cfg_w;
        n_cfg_h    = r_cfg_h;
        n_in_row   = r_in_row;
        n_in_col   = r_in_col;
        n_out_row  = r_out_row;
        n_out_col  = r_out_col;
        n_draining = r_draining;
        n_rd_row   = r_rd_row;
        n_rd_col   = r_rd_col;
        n_r1       = r_r1;
        n_c0       = r_c0;
        n_c1       = r_c1;
        n_count    = r_count;
        o_cmd      = '0;
        o_cmd.count = r_count;
        o_in_ready = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    // a pixel during drain is dropped and acts as a flush
                    if (i_in_mode == MODE_PIXEL && !r_draining) begin
                        o_cmd.wr_en = 1'b1;
                        if (r_in_col == aw - 1'b1) begin
                            n_in_col = '0;
                            if (r_in_row == ah - 1'b1) begin
                                n_in_row   = '0;
                                n_draining = 1'b1;
                            end else begin
                                n_in_row = r_in_row + 1'b1;
                            end
                        end else begin
                            n_in_col = r_in_col + 1'b1;
                        end
                    end
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (win_ready) begin
                    o_cmd.acc_clr = 1'b1;
                    n_rd_row = r0;
                    n_rd_col = c0;
                    n_r1     = rneed;
                    n_c0     = c0;
                    n_c1     = cneed;
                    n_count  = 4'(nr) * 4'(nc);
                    n_state  = ST_READ;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                if (r_rd_col == r_c1) begin
                    n_rd_col = r_c0;
                    if (r_rd_row == r_r1) begin
                        n_state = ST_RD_LAST;
                    end else begin
                        n_rd_row = r_rd_row + 1'b1;
                    end
                end else begin
                    n_rd_col = r_rd_col + 1'b1;
                end
            end
            ST_RD_LAST: begin
                // let the last read land in the accumulators
                n_state = ST_DIV_LD;
            end
            ST_DIV_LD: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = frame_end;
                    if (frame_end) begin
                        n_in_row   = '0;
                        n_in_col   = '0;
                        n_out_row  = '0;
                        n_out_col  = '0;
                        n_draining = 1'b0;
                    end else if (r_out_col == aw - 1'b1) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + 1'b1;
                    end else begin
                        n_out_col = r_out_col + 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // a register write restarts the frame
        if (i_cfg_we) begin
            if (i_cfg_idx == CFG_FRAME_WIDTH) begin
                n_cfg_w = i_cfg_data[CFG_W_BITS-1:0];
            end else begin
                n_cfg_h = i_cfg_data[CFG_H_BITS-1:0];
            end
            n_in_row   = '0;
            n_in_col   = '0;
            n_out_row  = '0;
            n_out_col  = '0;
            n_draining = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= RST_FRAME_WIDTH;
            r_cfg_h    <= RST_FRAME_HEIGHT;
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_draining <= 1'b0;
        end else begin
            r_cfg_w    <= n_cfg_w;
            r_cfg_h    <= n_cfg_h;
            r_in_row   <= n_in_row;
            r_in_col   <= n_in_col;
            r_out_row  <= n_out_row;
            r_out_col  <= n_out_col;
            r_draining <= n_draining;
        end
        r_rd_row <= n_rd_row;
        r_rd_col <= n_rd_col;
        r_r1     <= n_r1;
        r_c0     <= n_c0;
        r_c1     <= n_c1;
        r_count  <= n_count;
    end

    assign o_wr_row = r_in_row[1:0];
    assign o_wr_col = r_in_col[CW-1:0];
    assign o_rd_row = r_rd_row[1:0];
    assign o_rd_col = r_rd_col[CW-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/box_blur_3x3_clamped.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// box_blur_3x3_clamped: 3x3 edge-clamped box blur over an RGB pixel stream
// Pixels enter in raster order; each result is the rounded mean of the
// in-image 3x3 neighbourhood, emitted in raster order.
// ----------------------------------------------------------------------------
// Usage: an item that produces no result passes only the idle and check
// states. An item that releases a result then reads its neighbourhood pixels
// (1 to 9), one per cycle, through the single read port of the four-row pixel
// store, lets the last read accumulate, loads the divider, runs the reciprocal
// multiply that divides all three channels, and loads the output register
// once it is free. The result register lets the
// next item enter while a result waits. Send flush items (tuser = 1) after
// the last pixel of a frame to drain the remaining results; m_axis_tlast
// marks the final result of the frame. Writing either size register
// restarts the frame. The pixel store needs no clearing after reset.
module box_blur_3x3_clamped
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_idx,
    input  wire logic [CFG_D_BITS-1:0] i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [23:0]           s_axis_tdata,  // in_red, in_green, in_blue
    input  wire logic                  s_axis_tuser,  // mode
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [23:0]                m_axis_tdata,  // out_red, out_green, out_blue
    output logic                       m_axis_tlast
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    t_dp_cmd       cmd;
    t_dp_sts       sts;
    logic [1:0]    wr_row, rd_row;
    logic [CW-1:0] wr_col, rd_col;

    bb3_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .CW        (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(s_axis_tvalid),
        .i_in_mode (s_axis_tuser),
        .o_in_ready(s_axis_tready),
        .o_cmd     (cmd),
        .i_sts     (sts),
        .o_wr_row  (wr_row),
        .o_wr_col  (wr_col),
        .o_rd_row  (rd_row),
        .o_rd_col  (rd_col)
    );

    bb3_dp #(
        .CW(CW)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_wr_row   (wr_row),
        .i_wr_col   (wr_col),
        .i_wr_data  (s_axis_tdata),
        .i_rd_row   (rd_row),
        .i_rd_col   (rd_col),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .o_out_data (m_axis_tdata),
        .o_out_last (m_axis_tlast)
    );

endmodule
`default_nettype wire

// ===== rtl/core/bb3_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_chk: port-level checks for the box blur
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module bb3_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // reset leaves no result pending
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // each transaction is processed before the next is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken in back-to-back cycles");

endmodule

bind box_blur_3x3_clamped bb3_chk u_bb3_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
);
`default_nettype wire
